// ===== design/tlmv_pkg.sv =====
// tlmv_pkg: shared types for the track label majority vote block
// hit and summary payload structs, opcode enum, cell chain control struct
// no dependencies
package tlmv_pkg;

	localparam int unsigned LabelW    = 16;
	localparam int unsigned CountW    = 8;
	localparam int unsigned DistinctW = 7;

	typedef enum logic [1:0] {
		OP_LABEL = 2'd0,
		OP_FAKE  = 2'd1,
		OP_SKIP  = 2'd2,
		OP_EMPTY = 2'd3
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [LabelW-1:0] truth_label;
		logic              last_hit;
	} hit_t;

	typedef struct packed {
		logic                 best_valid;
		logic [LabelW-1:0]    best_label;
		logic [CountW-1:0]    true_count;
		logic [CountW-1:0]    wrong_count;
		logic [CountW-1:0]    fake_count;
		logic [DistinctW-1:0] distinct_labels;
		logic                 overflow;
	} sum_t;

	// control travelling with a hit along the cell chain
	typedef struct packed {
		logic vld;
		op_t  op;
		logic last;
		logic hit;
		logic fresh;
	} ctl_t;

endpackage

// ===== design/tlmv_cell.sv =====
// tlmv_cell: one table entry of the label chain
// holds a label and its count, passes the travelling hit on every cycle that adv is high
// depends on tlmv_pkg
module tlmv_cell #(
	parameter int unsigned LABEL_BITS = 16,
	parameter int unsigned COUNT_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  tlmv_pkg::ctl_t        prev_ctl,
	input  logic [LABEL_BITS-1:0] prev_label,
	input  logic [COUNT_BITS-1:0] prev_count,
	output tlmv_pkg::ctl_t        next_ctl,
	output logic [LABEL_BITS-1:0] next_label,
	output logic [COUNT_BITS-1:0] next_count
);
	import tlmv_pkg::*;

	localparam logic [COUNT_BITS-1:0] CountMax = '1;
	localparam logic [COUNT_BITS-1:0] CountOne = {{(COUNT_BITS-1){1'b0}}, 1'b1};

	logic                  valid_q;
	logic [LABEL_BITS-1:0] label_q;
	logic [COUNT_BITS-1:0] count_q;
	ctl_t                  ctl_s1;
	logic [LABEL_BITS-1:0] label_s1;
	logic [COUNT_BITS-1:0] count_s1;

	logic                  take;
	logic                  bump;
	logic                  alloc;
	logic                  ends;
	logic [COUNT_BITS-1:0] count_inc;
	ctl_t                  ctl_n;

	always_comb begin
		take      = prev_ctl.vld && (prev_ctl.op == OP_LABEL) && !prev_ctl.hit;
		bump      = take && valid_q && (label_q == prev_label);
		alloc     = take && !valid_q;
		ends      = prev_ctl.vld && ((prev_ctl.op == OP_EMPTY) || prev_ctl.last);
		count_inc = (count_q == CountMax) ? count_q : count_q + CountOne;
		ctl_n       = prev_ctl;
		ctl_n.hit   = prev_ctl.hit | bump | alloc;
		ctl_n.fresh = prev_ctl.fresh | alloc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			ctl_s1  <= '0;
		end else if (adv) begin
			ctl_s1 <= ctl_n;
			// track end clears the entry once the hit has passed
			if (ends) begin
				valid_q <= 1'b0;
			end else if (alloc) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			label_s1 <= prev_label;
			if (bump) begin
				count_s1 <= count_inc;
			end else if (alloc) begin
				count_s1 <= CountOne;
			end else begin
				count_s1 <= prev_count;
			end
			if (alloc) begin
				label_q <= prev_label;
				count_q <= CountOne;
			end else if (bump) begin
				count_q <= count_inc;
			end
		end
	end

	assign next_ctl   = ctl_s1;
	assign next_label = label_s1;
	assign next_count = count_s1;

endmodule

// ===== design/tlmv_tally.sv =====
// tlmv_tally: end of the label chain, running leader, tallies and summary register
// consumes hits leaving the last cell in order, emits one summary per track
// depends on tlmv_pkg
module tlmv_tally #(
	parameter int unsigned MAX_LABELS = 64,
	parameter int unsigned LABEL_BITS = 16,
	parameter int unsigned COUNT_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  tlmv_pkg::ctl_t        tail_ctl,
	input  logic [LABEL_BITS-1:0] tail_label,
	input  logic [COUNT_BITS-1:0] tail_count,
	output logic                  res_valid,
	output tlmv_pkg::sum_t        res
);
	import tlmv_pkg::*;

	localparam int unsigned UsedW = $clog2(MAX_LABELS + 1);
	localparam logic [COUNT_BITS-1:0] CountMax = '1;
	localparam logic [COUNT_BITS-1:0] CountOne = {{(COUNT_BITS-1){1'b0}}, 1'b1};
	localparam logic [UsedW-1:0]      UsedOne  = {{(UsedW-1){1'b0}}, 1'b1};

	logic [UsedW-1:0]      used_q,  used_n;
	logic [COUNT_BITS-1:0] fake_q,  fake_n;
	logic [COUNT_BITS-1:0] lab_q,   lab_n;
	logic [LABEL_BITS-1:0] lead_label_q, lead_label_n;
	logic [COUNT_BITS-1:0] lead_count_q, lead_count_n;
	logic                  ovf_q,   ovf_n;
	logic                  res_valid_q;
	sum_t                  res_q;

	logic                  ends;
	logic                  best;
	logic [COUNT_BITS-1:0] wrong;
	logic [LABEL_BITS+LabelW-1:0]    label_ext;
	logic [COUNT_BITS+CountW-1:0]    true_ext;
	logic [COUNT_BITS+CountW-1:0]    wrong_ext;
	logic [COUNT_BITS+CountW-1:0]    fake_ext;
	logic [UsedW+DistinctW-1:0]      used_ext;
	sum_t                  sum_n;

	always_comb begin
		used_n       = used_q;
		fake_n       = fake_q;
		lab_n        = lab_q;
		lead_label_n = lead_label_q;
		lead_count_n = lead_count_q;
		ovf_n        = ovf_q;
		if (tail_ctl.vld) begin
			case (tail_ctl.op)
				OP_LABEL: begin
					if (tail_ctl.hit) begin
						lab_n = (lab_q == CountMax) ? lab_q : lab_q + CountOne;
						if (tail_ctl.fresh) begin
							used_n = used_q + UsedOne;
						end
						if ((tail_count > lead_count_q) ||
						    ((tail_count == lead_count_q) && (tail_label < lead_label_q))) begin
							lead_count_n = tail_count;
							lead_label_n = tail_label;
						end
					end else begin
						// table full, label dropped
						ovf_n = 1'b1;
					end
				end
				OP_FAKE: begin
					fake_n = (fake_q == CountMax) ? fake_q : fake_q + CountOne;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		ends      = tail_ctl.vld && ((tail_ctl.op == OP_EMPTY) || tail_ctl.last);
		best      = lead_count_n != '0;
		wrong     = lab_n - lead_count_n;
		label_ext = {{LabelW{1'b0}}, (best ? lead_label_n : {LABEL_BITS{1'b0}})};
		true_ext  = {{CountW{1'b0}}, lead_count_n};
		wrong_ext = {{CountW{1'b0}}, wrong};
		fake_ext  = {{CountW{1'b0}}, fake_n};
		used_ext  = {{DistinctW{1'b0}}, used_n};
		sum_n.best_valid      = best;
		sum_n.best_label      = label_ext[LabelW-1:0];
		sum_n.true_count      = true_ext[CountW-1:0];
		sum_n.wrong_count     = wrong_ext[CountW-1:0];
		sum_n.fake_count      = fake_ext[CountW-1:0];
		sum_n.distinct_labels = used_ext[DistinctW-1:0];
		sum_n.overflow        = ovf_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q       <= '0;
			fake_q       <= '0;
			lab_q        <= '0;
			lead_label_q <= '0;
			lead_count_q <= '0;
			ovf_q        <= 1'b0;
			res_valid_q  <= 1'b0;
		end else if (adv) begin
			res_valid_q <= ends;
			if (ends) begin
				used_q       <= '0;
				fake_q       <= '0;
				lab_q        <= '0;
				lead_label_q <= '0;
				lead_count_q <= '0;
				ovf_q        <= 1'b0;
			end else begin
				used_q       <= used_n;
				fake_q       <= fake_n;
				lab_q        <= lab_n;
				lead_label_q <= lead_label_n;
				lead_count_q <= lead_count_n;
				ovf_q        <= ovf_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && ends) begin
			res_q <= sum_n;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ===== design/track_label_majority_vote.sv =====
// track_label_majority_vote: top level, cell chain plus tally stage
// depends on tlmv_pkg, tlmv_cell, tlmv_tally
//
// Hits of one track enter one per cycle and walk a chain of MAX_LABELS cells, one
// cell per cycle, while the chain advances; each cell owns one label entry and
// counts or claims the hit as it passes, so a following hit always sees the entries
// left by the one before it. The block takes a new hit every cycle unless a stalled
// summary holds it; a track's summary becomes valid once its closing hit or
// empty-track marker has passed the one register per cell and the summary register.
// A stalled summary holds the whole chain. Ties go to the
// smallest label, counts saturate at 2^COUNT_BITS - 1, and a new label arriving at
// a full table raises overflow and is ignored.
module track_label_majority_vote #(
	parameter int unsigned MAX_LABELS = 64,
	parameter int unsigned LABEL_BITS = 16,
	parameter int unsigned COUNT_BITS = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           hit_valid,
	output logic           hit_stall,
	input  tlmv_pkg::hit_t hit,
	output logic           sum_valid,
	input  logic           sum_stall,
	output tlmv_pkg::sum_t sum
);
	import tlmv_pkg::*;

	logic                  adv;
	logic [LABEL_BITS+LabelW-1:0] in_label_ext;
	ctl_t                  chain_ctl   [0:MAX_LABELS];
	logic [LABEL_BITS-1:0] chain_label [0:MAX_LABELS];
	logic [COUNT_BITS-1:0] chain_count [0:MAX_LABELS];

	assign adv       = !sum_valid || !sum_stall;
	assign hit_stall = !adv;

	assign in_label_ext = {{LABEL_BITS{1'b0}}, hit.truth_label};

	always_comb begin
		chain_ctl[0].vld   = hit_valid;
		chain_ctl[0].op    = hit.op;
		chain_ctl[0].last  = hit.last_hit;
		chain_ctl[0].hit   = 1'b0;
		chain_ctl[0].fresh = 1'b0;
	end
	assign chain_label[0] = in_label_ext[LABEL_BITS-1:0];
	assign chain_count[0] = '0;

	for (genvar i = 0; i < MAX_LABELS; i++) begin : g_cell
		tlmv_cell #(
			.LABEL_BITS (LABEL_BITS),
			.COUNT_BITS (COUNT_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.adv        (adv),
			.prev_ctl   (chain_ctl[i]),
			.prev_label (chain_label[i]),
			.prev_count (chain_count[i]),
			.next_ctl   (chain_ctl[i+1]),
			.next_label (chain_label[i+1]),
			.next_count (chain_count[i+1])
		);
	end

	tlmv_tally #(
		.MAX_LABELS (MAX_LABELS),
		.LABEL_BITS (LABEL_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_tally (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.tail_ctl   (chain_ctl[MAX_LABELS]),
		.tail_label (chain_label[MAX_LABELS]),
		.tail_count (chain_count[MAX_LABELS]),
		.res_valid  (sum_valid),
		.res        (sum)
	);

endmodule

// ===== design/tlmv_checker.sv =====
// tlmv_checker: port-level assertions for track_label_majority_vote, with its bind
// depends on tlmv_pkg and the top level's ports
module tlmv_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           hit_valid,
	input logic           hit_stall,
	input tlmv_pkg::hit_t hit,
	input logic           sum_valid,
	input logic           sum_stall,
	input tlmv_pkg::sum_t sum
);
	import tlmv_pkg::*;

	// a stalled summary transfer holds
	a_sum_hold: assert property (@(posedge clk) disable iff (!arst_n)
		sum_valid && sum_stall |=> sum_valid && $stable(sum))
		else $error("summary changed while stalled");

	// input only stalls behind a stalled summary
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		hit_stall |-> sum_valid && sum_stall)
		else $error("hit input stalled without output backpressure");

	// no majority label means empty label fields
	a_no_best: assert property (@(posedge clk) disable iff (!arst_n)
		sum_valid && !sum.best_valid |->
			(sum.best_label == '0) && (sum.true_count == '0) && (sum.wrong_count == '0))
		else $error("label fields set without a majority label");

endmodule

bind track_label_majority_vote tlmv_checker u_tlmv_checker (.*);
